@@ design/ecmp_pkg.sv @@
// ecmp_pkg: shared types, constants and helpers for the sensor compensation block
// no dependencies; used by the top level, ecmp_mul_lo, the checker and the bench
package ecmp_pkg;

  localparam int unsigned PW      = 64;   // pressure datapath width
  localparam int unsigned LATENCY = 83;   // start transfer to result strobe, in cycles

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DW    = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP       = 3'd0,
    CFG_PRESS_LOW  = 3'd1,
    CFG_PRESS_HIGH = 3'd2,
    CFG_PRESS_NINE = 3'd3,
    CFG_HUM        = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } in_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic [16:0]        humidity_q22_10;
    logic               pressure_invalid;
  } out_t;

  localparam logic signed [31:0] TEMP_MIN_CENTI = -32'sd4000;
  localparam logic signed [31:0] TEMP_MAX_CENTI = 32'sd8500;
  localparam logic signed [14:0] TEMP_MIN_OUT   = -15'sd4000;
  localparam logic signed [14:0] TEMP_MAX_OUT   = 15'sd8500;
  localparam logic signed [31:0] HUM_MAX_RAW    = 32'sd419430400;
  localparam logic [16:0]        HUM_MAX_OUT    = 17'd102400;
  localparam logic signed [31:0] HUM_T_OFFSET   = 32'sd76800;
  localparam logic [63:0]        PRESS_T_OFFSET = 64'd128000;
  localparam logic [63:0]        PRESS_ADC_FULL = 64'd1048576;
  localparam logic [63:0]        PRESS_DEN_BIAS = 64'h0000_8000_0000_0000;
  localparam logic [63:0]        PRESS_SCALE    = 64'd3125;

  // arithmetic right shift on a 64-bit two's-complement word
  function automatic logic [63:0] sra64(input logic [63:0] x, input int unsigned n);
    logic signed [63:0] s;
    s = $signed(x);
    return 64'(s >>> n);
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage

@@ design/env_sensor_compensation.sv @@
// env_sensor_compensation: pipelined temperature, pressure and humidity compensation
// depends on ecmp_pkg, ecmp_delay, ecmp_mul_lo, ecmp_div

// One raw reading set is taken per clock (start_i while busy_o is low) and its
// compensated result is on res_o, marked by result_strobe_o; results come out
// in order, one per transfer, and cannot be held off by the receiver. The
// latency is set by the 64-stage pipelined divider of the pressure formula;
// the other stages are the 64-bit product units and the 32-bit temperature
// and humidity chains. busy_o is high during reset and until the first clock
// edge after it. Calibration coefficients are written through the cfg port
// and are expected to stay put while readings are in flight. Temperature is
// saturated to -40.00..85.00 degC, humidity clamped to 0..100 %, and a zero
// pressure denominator gives pressure 0 with pressure_invalid set.
module env_sensor_compensation (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  ecmp_pkg::in_t                      in_i,
  output logic                               result_strobe_o,
  output ecmp_pkg::out_t                     res_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ecmp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ecmp_pkg::CFG_DW-1:0]        cfg_data_i
);

  localparam int unsigned PW = ecmp_pkg::PW;
  localparam int unsigned LAT = ecmp_pkg::LATENCY;

  // ---------------- control ----------------
  logic           busy_q;
  logic           accept;
  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o      = busy_q;
  assign cfg_ready_o = !busy_q;
  assign accept      = start_i && !busy_q;

  // valid bit travels alongside the item, one bit per stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  // ---------------- coefficient registers ----------------
  logic [47:0] temp_cfg_q;
  logic [63:0] plow_cfg_q, phigh_cfg_q, hum_cfg_q;
  logic [15:0] p9_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cfg_q  <= '0;
      plow_cfg_q  <= '0;
      phigh_cfg_q <= '0;
      p9_cfg_q    <= '0;
      hum_cfg_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (ecmp_pkg::cfg_idx_e'(cfg_index_i))
        ecmp_pkg::CFG_TEMP:       temp_cfg_q  <= cfg_data_i[47:0];
        ecmp_pkg::CFG_PRESS_LOW:  plow_cfg_q  <= cfg_data_i;
        ecmp_pkg::CFG_PRESS_HIGH: phigh_cfg_q <= cfg_data_i;
        ecmp_pkg::CFG_PRESS_NINE: p9_cfg_q    <= cfg_data_i[15:0];
        ecmp_pkg::CFG_HUM:        hum_cfg_q   <= cfg_data_i;
        default: ;  // unknown register index, write dropped
      endcase
    end
  end

  // coefficient fields
  logic [15:0]        t1;
  logic signed [15:0] t2, t3;
  logic [7:0]         h1, h3;
  logic signed [15:0] h2;
  logic signed [11:0] h4, h5;
  logic signed [7:0]  h6;
  logic [PW-1:0]      p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_cfg_q[15:0];
  assign t2 = temp_cfg_q[31:16];
  assign t3 = temp_cfg_q[47:32];
  assign h1 = hum_cfg_q[7:0];
  assign h2 = hum_cfg_q[23:8];
  assign h3 = hum_cfg_q[31:24];
  assign h4 = hum_cfg_q[43:32];
  assign h5 = hum_cfg_q[55:44];
  assign h6 = hum_cfg_q[63:56];
  assign p1 = {48'b0, plow_cfg_q[15:0]};
  assign p2 = ecmp_pkg::sx16(plow_cfg_q[31:16]);
  assign p3 = ecmp_pkg::sx16(plow_cfg_q[47:32]);
  assign p4 = ecmp_pkg::sx16(plow_cfg_q[63:48]);
  assign p5 = ecmp_pkg::sx16(phigh_cfg_q[15:0]);
  assign p6 = ecmp_pkg::sx16(phigh_cfg_q[31:16]);
  assign p7 = ecmp_pkg::sx16(phigh_cfg_q[47:32]);
  assign p8 = ecmp_pkg::sx16(phigh_cfg_q[63:48]);
  assign p9 = ecmp_pkg::sx16(p9_cfg_q);

  // ---------------- stage 0: input capture ----------------
  ecmp_pkg::in_t in_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_i;
    end
  end

  // ---------------- temperature, stages 1..4 ----------------
  logic signed [17:0] tx1;
  logic signed [16:0] tdt;
  logic signed [31:0] m1_q, dd_q, v1_q, m3_q, tfine_q, tdd12, tscaled, tsat;
  logic signed [14:0] temp_q;

  assign tx1 = $signed({1'b0, in_q.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign tdt = $signed({1'b0, in_q.raw_temperature[19:4]}) - $signed({1'b0, t1});
  assign tdd12 = dd_q >>> 12;

  always_ff @(posedge clk_i) begin
    m1_q    <= 32'(tx1) * 32'(t2);
    dd_q    <= 32'(tdt) * 32'(tdt);
    v1_q    <= m1_q >>> 11;
    m3_q    <= tdd12 * 32'(t3);
    tfine_q <= v1_q + (m3_q >>> 14);   // fine temperature, degC * 5120
  end

  assign tscaled = (tfine_q * 32'sd5 + 32'sd128) >>> 8;

  always_comb begin
    tsat = tscaled;
    if (tscaled < ecmp_pkg::TEMP_MIN_CENTI) begin
      tsat = ecmp_pkg::TEMP_MIN_CENTI;
    end else if (tscaled > ecmp_pkg::TEMP_MAX_CENTI) begin
      tsat = ecmp_pkg::TEMP_MAX_CENTI;
    end
  end

  always_ff @(posedge clk_i) begin
    temp_q <= tsat[14:0];
  end

  // ---------------- humidity, stages 4..10 ----------------
  logic [15:0]        adc_h_d4;
  logic signed [31:0] hx, mh5_q, mh6_q, mh3_q, ha_q, ha2_q, him_q, hbm_q, hi, hb;
  logic signed [31:0] x2_q, x2b_q, x2c_q, sq_q, mh1_q, x2s15, hr, hc;
  logic [16:0]        hum_q;

  ecmp_delay #(.WIDTH(16), .DEPTH(4)) u_dly_adc_h (
    .clk_i, .d_i(in_q.raw_humidity), .q_o(adc_h_d4)
  );

  assign hx    = tfine_q - ecmp_pkg::HUM_T_OFFSET;
  assign hi    = (him_q >>> 10) + 32'sd2097152;
  assign hb    = (hbm_q + 32'sd8192) >>> 14;
  assign x2s15 = x2_q >>> 15;

  always_ff @(posedge clk_i) begin
    mh5_q <= hx * 32'(h5);
    mh6_q <= hx * 32'(h6);
    mh3_q <= hx * $signed({24'b0, h3});
    ha_q  <= ($signed({2'b0, adc_h_d4, 14'b0}) - (32'(h4) <<< 20) - mh5_q
              + 32'sd16384) >>> 15;
    him_q <= (mh6_q >>> 10) * ((mh3_q >>> 11) + 32'sd32768);
    hbm_q <= hi * 32'(h2);
    ha2_q <= ha_q;
    x2_q  <= ha2_q * hb;
    sq_q  <= x2s15 * x2s15;
    x2b_q <= x2_q;
    mh1_q <= (sq_q >>> 7) * $signed({24'b0, h1});
    x2c_q <= x2b_q;
  end

  assign hr = x2c_q - (mh1_q >>> 4);

  always_comb begin
    hc = hr;
    if (hr < 32'sd0) begin
      hc = 32'sd0;
    end else if (hr > ecmp_pkg::HUM_MAX_RAW) begin
      hc = ecmp_pkg::HUM_MAX_RAW;
    end
  end

  always_ff @(posedge clk_i) begin
    hum_q <= hc[28:12];
  end

  // ---------------- pressure: denominator and numerator, stages 3..11 ----------------
  logic [PW-1:0] pa, pa_d2, aa, b1, d1, ap5, ap2, b_q, a2_q;
  logic [PW-1:0] den_m, num_m, pden, pp, pnum;
  logic [19:0]   adc_p_d8;
  logic [PW-1:0] nmag_q, dmag_q;
  logic          neg_q, inv_q;

  assign pa = {{32{tfine_q[31]}}, tfine_q} - ecmp_pkg::PRESS_T_OFFSET;

  ecmp_delay #(.WIDTH(PW), .DEPTH(2)) u_dly_a (.clk_i, .d_i(pa), .q_o(pa_d2));
  ecmp_delay #(.WIDTH(20), .DEPTH(8)) u_dly_adc_p (
    .clk_i, .d_i(in_q.raw_pressure), .q_o(adc_p_d8)
  );

  ecmp_mul_lo u_mul_aa  (.clk_i, .a_i(pa),    .b_i(pa), .p_o(aa));
  ecmp_mul_lo u_mul_b1  (.clk_i, .a_i(aa),    .b_i(p6), .p_o(b1));
  ecmp_mul_lo u_mul_d1  (.clk_i, .a_i(aa),    .b_i(p3), .p_o(d1));
  ecmp_mul_lo u_mul_ap5 (.clk_i, .a_i(pa_d2), .b_i(p5), .p_o(ap5));
  ecmp_mul_lo u_mul_ap2 (.clk_i, .a_i(pa_d2), .b_i(p2), .p_o(ap2));

  always_ff @(posedge clk_i) begin
    b_q  <= b1 + (ap5 << 17) + (p4 << 35);
    a2_q <= ecmp_pkg::sra64(d1, 8) + (ap2 << 12);
  end

  assign pp   = ecmp_pkg::PRESS_ADC_FULL - {44'b0, adc_p_d8};
  assign pnum = (pp << 31) - b_q;

  ecmp_mul_lo u_mul_den (
    .clk_i, .a_i(ecmp_pkg::PRESS_DEN_BIAS + a2_q), .b_i(p1), .p_o(den_m)
  );
  ecmp_mul_lo u_mul_num (.clk_i, .a_i(pnum), .b_i(ecmp_pkg::PRESS_SCALE), .p_o(num_m));

  assign pden = ecmp_pkg::sra64(den_m, 33);

  // signed division runs on magnitudes; the sign is applied after the divider
  always_ff @(posedge clk_i) begin
    nmag_q <= num_m[PW-1] ? (PW'(0) - num_m) : num_m;
    dmag_q <= pden[PW-1] ? (PW'(0) - pden) : pden;
    neg_q  <= num_m[PW-1] ^ pden[PW-1];
    inv_q  <= (pden == '0);
  end

  // ---------------- pressure: divider, stages 12..75 ----------------
  logic [PW-1:0] quo;
  logic          neg_d;
  logic [PW-1:0] p_q;

  ecmp_div #(.WIDTH(PW)) u_div (.clk_i, .num_i(nmag_q), .den_i(dmag_q), .quo_o(quo));
  ecmp_delay #(.WIDTH(1), .DEPTH(PW)) u_dly_neg (.clk_i, .d_i(neg_q), .q_o(neg_d));

  always_ff @(posedge clk_i) begin
    p_q <= neg_d ? (PW'(0) - quo) : quo;
  end

  // ---------------- pressure: correction terms, stages 76..81 ----------------
  logic [PW-1:0] p_d2, p_d4, c1, c2, dm, dm_d2, s_q, pres;

  ecmp_delay #(.WIDTH(PW), .DEPTH(2)) u_dly_p2 (.clk_i, .d_i(p_q),  .q_o(p_d2));
  ecmp_delay #(.WIDTH(PW), .DEPTH(2)) u_dly_p4 (.clk_i, .d_i(p_d2), .q_o(p_d4));
  ecmp_delay #(.WIDTH(PW), .DEPTH(2)) u_dly_dm (.clk_i, .d_i(dm),   .q_o(dm_d2));

  ecmp_mul_lo u_mul_c1 (.clk_i, .a_i(p9), .b_i(ecmp_pkg::sra64(p_q, 13)),  .p_o(c1));
  ecmp_mul_lo u_mul_dm (.clk_i, .a_i(p8), .b_i(p_q), .p_o(dm));
  ecmp_mul_lo u_mul_c2 (.clk_i, .a_i(c1), .b_i(ecmp_pkg::sra64(p_d2, 13)), .p_o(c2));

  always_ff @(posedge clk_i) begin
    s_q <= p_d4 + ecmp_pkg::sra64(c2, 25) + ecmp_pkg::sra64(dm_d2, 19);
  end

  assign pres = ecmp_pkg::sra64(s_q, 8) + (p7 << 4);

  // ---------------- side results aligned to stage 81 ----------------
  logic          inv_d;
  logic [14:0]   temp_d;
  logic [16:0]   hum_d;

  ecmp_delay #(.WIDTH(1),  .DEPTH(70)) u_dly_inv  (.clk_i, .d_i(inv_q),  .q_o(inv_d));
  ecmp_delay #(.WIDTH(15), .DEPTH(77)) u_dly_temp (.clk_i, .d_i(temp_q), .q_o(temp_d));
  ecmp_delay #(.WIDTH(17), .DEPTH(71)) u_dly_hum  (.clk_i, .d_i(hum_q),  .q_o(hum_d));

  // ---------------- output register, stage 82 ----------------
  ecmp_pkg::out_t res_q;

  always_ff @(posedge clk_i) begin
    res_q.temperature_centi <= $signed(temp_d);
    res_q.pressure_q24_8    <= inv_d ? 32'd0 : pres[31:0];
    res_q.humidity_q22_10   <= hum_d;
    res_q.pressure_invalid  <= inv_d;
  end

  assign res_o           = res_q;
  assign result_strobe_o = vld_q[LAT-1];

endmodule

@@ design/ecmp_delay.sv @@
// ecmp_delay: fixed-depth shift line that keeps side data aligned with the datapath
// depends on nothing
module ecmp_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i) begin
    pipe_q[0] <= d_i;
    for (int unsigned k = 1; k < DEPTH; k++) begin
      pipe_q[k] <= pipe_q[k-1];
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule

@@ design/ecmp_mul_lo.sv @@
// ecmp_mul_lo: low half of a 64x64 product in two stages of 32-bit partial products
// depends on ecmp_pkg
module ecmp_mul_lo (
  input  logic                      clk_i,
  input  logic [ecmp_pkg::PW-1:0]   a_i,
  input  logic [ecmp_pkg::PW-1:0]   b_i,
  output logic [ecmp_pkg::PW-1:0]   p_o
);

  localparam int unsigned HW = ecmp_pkg::PW / 2;

  logic [ecmp_pkg::PW-1:0] ll_q, p_q;
  logic [HW-1:0]           lh_q, hl_q;

  always_ff @(posedge clk_i) begin
    ll_q <= ecmp_pkg::PW'(a_i[HW-1:0]) * ecmp_pkg::PW'(b_i[HW-1:0]);
    lh_q <= a_i[HW-1:0] * b_i[ecmp_pkg::PW-1:HW];
    hl_q <= a_i[ecmp_pkg::PW-1:HW] * b_i[HW-1:0];
    p_q  <= ll_q + {lh_q + hl_q, {HW{1'b0}}};
  end

  assign p_o = p_q;

endmodule

@@ design/ecmp_div.sv @@
// ecmp_div: unsigned restoring divider, one quotient bit per register stage
// depends on nothing; magnitudes must not exceed 2**(WIDTH-1)
module ecmp_div #(
  parameter int unsigned WIDTH = 64
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] num_i,
  input  logic [WIDTH-1:0] den_i,
  output logic [WIDTH-1:0] quo_o
);

  logic [WIDTH-1:0] rem_q [WIDTH];
  logic [WIDTH-1:0] num_q [WIDTH];
  logic [WIDTH-1:0] den_q [WIDTH];

  for (genvar i = 0; i < WIDTH; i++) begin : g_step
    logic [WIDTH-1:0] rem_in, num_in, den_in, trial;
    logic             fits;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign num_in = num_q[i-1];
      assign den_in = den_q[i-1];
    end

    // remainder stays below the divisor, so its top bit is free
    assign trial = {rem_in[WIDTH-2:0], num_in[WIDTH-1]};
    assign fits  = (trial >= den_in);

    always_ff @(posedge clk_i) begin
      rem_q[i] <= fits ? (trial - den_in) : trial;
      num_q[i] <= {num_in[WIDTH-2:0], fits};
      den_q[i] <= den_in;
    end
  end

  assign quo_o = num_q[WIDTH-1];

endmodule

@@ design/ecmp_checker.sv @@
// ecmp_checker: port-level timing and range checks for env_sensor_compensation
// depends on ecmp_pkg; bound to the top level below
module ecmp_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               busy_o,
  input  ecmp_pkg::in_t                      in_i,
  input  logic                               result_strobe_o,
  input  ecmp_pkg::out_t                     res_o,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_o,
  input  logic [ecmp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ecmp_pkg::CFG_DW-1:0]        cfg_data_i
);

  // every start transfer gives a result after the fixed latency
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(ecmp_pkg::LATENCY) result_strobe_o)
    else $error("missing result after start transfer");

  // no result without a start transfer at the matching time
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(start_i && !busy_o, ecmp_pkg::LATENCY))
    else $error("result without a start transfer");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && res_o.pressure_invalid) |-> (res_o.pressure_q24_8 == 32'd0))
    else $error("invalid pressure not forced to zero");

  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> (res_o.temperature_centi >= ecmp_pkg::TEMP_MIN_OUT
                         && res_o.temperature_centi <= ecmp_pkg::TEMP_MAX_OUT
                         && res_o.humidity_q22_10 <= ecmp_pkg::HUM_MAX_OUT))
    else $error("temperature or humidity out of range");

endmodule

bind env_sensor_compensation ecmp_checker u_ecmp_checker (.*);

@@ bench/tb_top.sv @@
// tb_top: self-checking bench for env_sensor_compensation
// depends on ecmp_pkg and the design; predicts each compensated reading set
// from the shadow coefficient copies and compares every result strobe against it
module tb_top;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  ecmp_pkg::in_t reading = '0;
  logic res_strobe;
  ecmp_pkg::out_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ecmp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ecmp_pkg::CFG_DW-1:0] cfg_data = '0;

  // coefficient shadow copies
  logic [47:0] temp_cal = '0;
  logic [63:0] press_cal_lo = '0;
  logic [63:0] press_cal_hi = '0;
  logic [15:0] press_cal_p9 = '0;
  logic [63:0] hum_cal = '0;

  ecmp_pkg::out_t compensated_q[$];
  int err_cnt = 0;
  bit idle_gaps = 1'b1;

  always #4 clk = ~clk;

  env_sensor_compensation DUT (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy), .in_i(reading),
    .result_strobe_o(res_strobe), .res_o(res), .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  function automatic logic [31:0] asr32(logic [31:0] x, int n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int n);
    return 64'($signed(x) >>> n);
  endfunction

  // fixed-point compensation of one reading set
  function automatic ecmp_pkg::out_t compensate(ecmp_pkg::in_t r);
    ecmp_pkg::out_t o;
    logic [31:0] t1, t2, t3, v1, v2, dt, tfine, tc;
    logic [63:0] a, b, den, num, p, c, d, p1, p2, p3, p4, p5, p6, p7, p8, p9, mn, md, q;
    logic [31:0] h1, h2, h3, h4, h5, h6, x, ha, hi, hb;
    logic signed [31:0] ts, hs;
    t1 = {16'd0, temp_cal[15:0]};
    t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
    t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
    v1 = asr32(((32'(r.raw_temperature) >> 3) - (t1 << 1)) * t2, 11);
    dt = (32'(r.raw_temperature) >> 4) - t1;
    v2 = asr32(asr32(dt * dt, 12) * t3, 14);
    tfine = v1 + v2;
    ts = $signed(asr32(tfine * 5 + 128, 8));
    if (ts < ecmp_pkg::TEMP_MIN_CENTI) ts = ecmp_pkg::TEMP_MIN_CENTI;
    if (ts > ecmp_pkg::TEMP_MAX_CENTI) ts = ecmp_pkg::TEMP_MAX_CENTI;
    o.temperature_centi = ts[14:0];

    p1 = {48'd0, press_cal_lo[15:0]};
    p2 = {{48{press_cal_lo[31]}}, press_cal_lo[31:16]};
    p3 = {{48{press_cal_lo[47]}}, press_cal_lo[47:32]};
    p4 = {{48{press_cal_lo[63]}}, press_cal_lo[63:48]};
    p5 = {{48{press_cal_hi[15]}}, press_cal_hi[15:0]};
    p6 = {{48{press_cal_hi[31]}}, press_cal_hi[31:16]};
    p7 = {{48{press_cal_hi[47]}}, press_cal_hi[47:32]};
    p8 = {{48{press_cal_hi[63]}}, press_cal_hi[63:48]};
    p9 = {{48{press_cal_p9[15]}}, press_cal_p9};
    a = {{32{tfine[31]}}, tfine} - 64'd128000;
    b = a * a * p6;
    b = b + ((a * p5) << 17);
    b = b + (p4 << 35);
    den = asr64(a * a * p3, 8) + ((a * p2) << 12);
    den = asr64(((64'd1 << 47) + den) * p1, 33);
    o.pressure_invalid = (den == '0);
    o.pressure_q24_8 = '0;
    if (den != '0) begin
      num = (((64'd1048576 - 64'(r.raw_pressure)) << 31) - b) * 64'd3125;
      mn = num[63] ? -num : num;
      md = den[63] ? -den : den;
      q = mn / md;
      p = (num[63] != den[63]) ? -q : q;
      c = asr64(p9 * asr64(p, 13) * asr64(p, 13), 25);
      d = asr64(p8 * p, 19);
      p = asr64(p + c + d, 8) + (p7 << 4);
      o.pressure_q24_8 = p[31:0];
    end

    h1 = {24'd0, hum_cal[7:0]};
    h2 = {{16{hum_cal[23]}}, hum_cal[23:8]};
    h3 = {24'd0, hum_cal[31:24]};
    h4 = {{20{hum_cal[43]}}, hum_cal[43:32]};
    h5 = {{20{hum_cal[55]}}, hum_cal[55:44]};
    h6 = {{24{hum_cal[63]}}, hum_cal[63:56]};
    x = tfine - 32'd76800;
    ha = asr32((32'(r.raw_humidity) << 14) - (h4 << 20) - (h5 * x) + 32'd16384, 15);
    hi = asr32(asr32(x * h6, 10) * (asr32(x * h3, 11) + 32'd32768), 10) + 32'd2097152;
    hb = asr32(hi * h2 + 32'd8192, 14);
    x = ha * hb;
    x = x - asr32(asr32(asr32(x, 15) * asr32(x, 15), 7) * h1, 4);
    hs = $signed(x);
    if (hs < 0) hs = 0;
    if (hs > ecmp_pkg::HUM_MAX_RAW) hs = ecmp_pkg::HUM_MAX_RAW;
    tc = hs;
    o.humidity_q22_10 = tc[28:12];
    return o;
  endfunction

  // one reading set transfer, with random gaps ahead of it while idle_gaps is set; start stays high
  // on return so a following transfer can go back to back
  task automatic send_reading(ecmp_pkg::in_t r);
    while (idle_gaps && $urandom_range(99) < 28) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    reading <= r;
    compensated_q.push_back(compensate(r));
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // coefficient write, only issued while nothing is in flight
  task automatic write_cal(ecmp_pkg::cfg_idx_e idx, logic [63:0] val);
    start <= 1'b0;
    while (compensated_q.size() != 0) @(posedge clk);
    repeat (ecmp_pkg::LATENCY + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      ecmp_pkg::CFG_TEMP:       temp_cal = val[47:0];
      ecmp_pkg::CFG_PRESS_LOW:  press_cal_lo = val;
      ecmp_pkg::CFG_PRESS_HIGH: press_cal_hi = val;
      ecmp_pkg::CFG_PRESS_NINE: press_cal_p9 = val[15:0];
      default:                  hum_cal = val;
    endcase
  endtask

  // result checker: strobe is sampled at the edge that ends the cycle
  always @(posedge clk) begin
    if (rst_n && res_strobe) begin
      if (compensated_q.size() == 0) begin
        $error("unexpected result transfer");
        err_cnt++;
      end else begin
        automatic ecmp_pkg::out_t e = compensated_q.pop_front();
        if (res.temperature_centi !== e.temperature_centi) begin
          $error("temperature_centi exp %0d got %0d", e.temperature_centi,
                 res.temperature_centi);
          err_cnt++;
        end
        if (res.pressure_q24_8 !== e.pressure_q24_8) begin
          $error("pressure_q24_8 exp %h got %h", e.pressure_q24_8, res.pressure_q24_8);
          err_cnt++;
        end
        if (res.humidity_q22_10 !== e.humidity_q22_10) begin
          $error("humidity_q22_10 exp %0d got %0d", e.humidity_q22_10,
                 res.humidity_q22_10);
          err_cnt++;
        end
        if (res.pressure_invalid !== e.pressure_invalid) begin
          $error("pressure_invalid exp %b got %b", e.pressure_invalid,
                 res.pressure_invalid);
          err_cnt++;
        end
      end
    end
  end

  function automatic ecmp_pkg::in_t rand_reading();
    ecmp_pkg::in_t r;
    r.raw_temperature = 20'($urandom);
    r.raw_pressure = 20'($urandom);
    r.raw_humidity = 16'($urandom);
    return r;
  endfunction

  // plausible factory-like coefficient set with random spread
  task automatic load_factory_cal();
    write_cal(ecmp_pkg::CFG_TEMP, {16'($urandom_range(45, 55)),
                                   16'($urandom_range(26000, 27000)),
                                   16'($urandom_range(27500, 28500))});
    write_cal(ecmp_pkg::CFG_PRESS_LOW, {16'($urandom_range(2000, 3000)),
                                        16'(-$urandom_range(0, 4000) + 3000),
                                        16'(-$urandom_range(10000, 11000)),
                                        16'($urandom_range(36000, 38000))});
    write_cal(ecmp_pkg::CFG_PRESS_HIGH, {16'($urandom_range(0, 4000) - 2000),
                                         16'($urandom_range(0, 40)),
                                         16'(-$urandom_range(1, 100)),
                                         16'($urandom_range(0, 300) - 150)});
    write_cal(ecmp_pkg::CFG_PRESS_NINE, 64'(16'($urandom_range(4000, 6000))));
    write_cal(ecmp_pkg::CFG_HUM, {8'($urandom_range(20, 40)), 12'($urandom_range(0, 60)),
                                  12'($urandom_range(280, 360)), 8'($urandom_range(0, 10)),
                                  16'($urandom_range(340, 380)), 8'($urandom_range(60, 90))});
  endtask

  // field extremes with all-zero coefficients, then all-one and random readings with all-one coefficients
  task automatic test_extremes();
    ecmp_pkg::in_t r;
    for (int k = 0; k < 8; k++) begin
      r.raw_temperature = k[0] ? 20'hFFFFF : 20'h0;
      r.raw_pressure = k[1] ? 20'hFFFFF : 20'h0;
      r.raw_humidity = k[2] ? 16'hFFFF : 16'h0;
      send_reading(r);
    end
    write_cal(ecmp_pkg::CFG_TEMP, '1);
    write_cal(ecmp_pkg::CFG_PRESS_LOW, '1);
    write_cal(ecmp_pkg::CFG_PRESS_HIGH, '1);
    write_cal(ecmp_pkg::CFG_PRESS_NINE, '1);
    write_cal(ecmp_pkg::CFG_HUM, '1);
    for (int k = 0; k < 4; k++) send_reading(k[0] ? rand_reading() : ecmp_pkg::in_t'('1));
  endtask

  // zero denominator, saturation and clamping under realistic coefficients
  task automatic test_special_cases();
    load_factory_cal();
    // P1 = 0 kills the denominator
    write_cal(ecmp_pkg::CFG_PRESS_LOW, press_cal_lo & ~64'hFFFF);
    send_reading(rand_reading());
    send_reading('1);
    load_factory_cal();
    send_reading({20'h0, 20'h80000, 16'h0});        // cold end, dry
    send_reading({20'hFFFFF, 20'h80000, 16'hFFFF}); // hot end, wet
    send_reading({20'h7E000, 20'h5A000, 16'h6800});
    send_reading({20'h80000, 20'h0, 16'h8000});
    send_reading({20'h80000, 20'hFFFFF, 16'h4000});
  endtask

  // random readings across several coefficient sets, including raw random ones
  task automatic test_random();
    for (int s = 0; s < 6; s++) begin
      if (s % 3 == 2) begin
        write_cal(ecmp_pkg::CFG_TEMP, {$urandom, $urandom});
        write_cal(ecmp_pkg::CFG_PRESS_LOW, {$urandom, $urandom});
        write_cal(ecmp_pkg::CFG_PRESS_HIGH, {$urandom, $urandom});
        write_cal(ecmp_pkg::CFG_PRESS_NINE, {$urandom, $urandom});
        write_cal(ecmp_pkg::CFG_HUM, {$urandom, $urandom});
      end else begin
        load_factory_cal();
      end
      idle_gaps = (s != 1);  // one long stretch with back-to-back transfers
      repeat (105) send_reading(rand_reading());
    end
    idle_gaps = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_special_cases();
    test_random();
    start <= 1'b0;
    while (compensated_q.size() != 0) @(posedge clk);
    repeat (ecmp_pkg::LATENCY + 10) @(posedge clk);
    if (err_cnt == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end
endmodule

@@ files.f @@
design/ecmp_pkg.sv
design/ecmp_delay.sv
design/ecmp_mul_lo.sv
design/ecmp_div.sv
design/env_sensor_compensation.sv
design/ecmp_checker.sv
bench/tb_top.sv
